/* sv/bitmap_run_allocator_top_macros.svh */
// Assertion helpers for the run allocator
`ifndef BITMAP_RUN_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_TOP_MACROS_SVH
// check a property on every clock edge outside reset
`define BRA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// check a property including the reset cycles
`define BRA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);
`endif

/* sv/bra_pkg.sv */
package bra_pkg;
   localparam int MAP_BITS    = 4096;
   localparam int WORD_BITS   = 64;
   localparam int STORE_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW     = $clog2(STORE_WORDS);
   localparam int BIT_AW      = $clog2(WORD_BITS);
   localparam int LEN_W       = $clog2(MAP_BITS + 1);
   localparam int RUN_W       = 13;
   localparam logic [9:0] MAP_BYTES_RESET = 10'd512;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [1:0] REG_MAP_BYTES = 2'd0;

   typedef enum logic [1:0] {
      CMD_SCAN  = 2'd0,
      CMD_TEST  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [11:0] bit_index;
      logic        bit_value;
      logic [12:0] run_length;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [11:0] start_index;
      logic        bit_state;
   } rsp_type;

   // classified request handed to the back end
   typedef struct packed {
      cmd_type            cmd;
      logic               in_store;
      logic [WORD_AW-1:0] word;
      logic [BIT_AW-1:0]  bit_pos;
      logic               bit_value;
      logic [RUN_W-1:0]   run_length;
      logic               bad_count;
   } job_type;
endpackage

/* sv/bra_front.sv */
module bra_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bra_pkg::req_type req_data,
   input  logic             pop,
   output logic             job_valid,
   output bra_pkg::job_type job
);
   localparam int PW = $clog2(bra_pkg::QUEUE_DEPTH);

   bra_pkg::job_type          q_ff [bra_pkg::QUEUE_DEPTH];
   logic [PW-1:0]             wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]               cnt_ff, cnt_in;
   logic                      push;
   bra_pkg::job_type          cls;

   // classify the request
   always_comb begin
      cls.cmd        = bra_pkg::cmd_type'(req_data.cmd);
      cls.in_store   = ({20'd0, req_data.bit_index} < 32'(bra_pkg::MAP_BITS));
      cls.word       = bra_pkg::WORD_AW'(req_data.bit_index >> bra_pkg::BIT_AW);
      cls.bit_pos    = req_data.bit_index[bra_pkg::BIT_AW-1:0];
      cls.bit_value  = req_data.bit_value;
      cls.run_length = req_data.run_length;
      cls.bad_count  = (req_data.run_length == '0);
   end

   assign busy      = (cnt_ff == (PW+1)'(bra_pkg::QUEUE_DEPTH));
   assign push      = start && !busy;
   assign job_valid = (cnt_ff != '0);
   assign job       = q_ff[rp_ff];

   // advance queue pointers
   always_comb begin
      wp_in  = push ? PW'(wp_ff + 1'b1) : wp_ff;
      rp_in  = pop  ? PW'(rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= cls;
   end

   `include "bitmap_run_allocator_top_macros.svh"
   `BRA_ASSERT(a_no_pop_empty, pop |-> job_valid, "pop from empty queue")
   `BRA_ASSERT(a_cnt_bound, cnt_ff <= (PW+1)'(bra_pkg::QUEUE_DEPTH), "queue overflow")
   `BRA_ASSERT(a_cnt_track, (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1, "count slip")
endmodule

/* sv/bra_back.sv */
module bra_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  bra_pkg::job_type  job,
   output logic              pop,
   input  logic [9:0]        map_bytes,
   output logic              rsp_valid,
   output bra_pkg::rsp_type  rsp_data
);
   localparam int WA = bra_pkg::WORD_AW;
   localparam int WB = bra_pkg::WORD_BITS;
   localparam int LW = bra_pkg::LEN_W;
   localparam int BA = bra_pkg::BIT_AW;

   logic [WB-1:0]   mem [bra_pkg::STORE_WORDS];
   logic [WB-1:0]   rd_ff;
   logic            rd_ok_ff;

   bra_pkg::state_type st_ff, st_in;
   bra_pkg::job_type   cur_ff, cur_in;
   logic [WA:0]        widx_ff, widx_in;
   logic [LW-1:0]      base_ff, base_in;
   logic [12:0]        run_ff, run_in;
   logic [LW-1:0]      len;
   logic               rmw_ff, rmw_in;
   logic               rv_ff, rv_in;
   bra_pkg::rsp_type   rsp_ff, rsp_in;
   logic               cur_ok_ff;

   logic              mem_we;
   logic [WA-1:0]     mem_wa;
   logic [WB-1:0]     mem_wd;
   logic              rd_en;
   logic [WA-1:0]     rd_addr;

   logic [12:0]       run_t;
   logic              hit;
   logic [LW-1:0]     hit_pos;
   logic [LW-1:0]     lim;
   logic [WB-1:0]     win_mask;
   logic [WB-1:0]     hv;
   logic [BA-1:0]     hit_off;
   logic [BA-1:0]     top_one;

   // saturate map length
   always_comb begin
      lim = ({1'b0, map_bytes, 3'b000} > 14'(bra_pkg::MAP_BITS)) ?
            LW'(bra_pkg::MAP_BITS) : LW'({map_bytes, 3'b000});
      len = lim;
   end

   // check every bit of one word in parallel for the end of a long enough free run
   always_comb begin
      if (cur_ff.run_length >= 13'(WB)) win_mask = '1;
      else win_mask = ~({WB{1'b1}} >> cur_ff.run_length[BA-1:0]);
      for (int b = 0; b < WB; b++) begin
         hv[b] = (LW'(base_ff + LW'(b)) < len) &&
                 (((13'(b + 1) >= cur_ff.run_length) &&
                   (((rd_ff << (WB - 1 - b)) & win_mask) == '0)) ||
                  (((rd_ff << (WB - 1 - b)) == '0) &&
                   (14'(run_ff) + 14'(b + 1) >= 14'(cur_ff.run_length))));
      end
      hit = |hv;
      // pick the lowest hit
      hit_off = '0;
      for (int b = WB - 1; b >= 0; b--) begin
         if (hv[b]) hit_off = BA'(b);
      end
      hit_pos = LW'(base_ff + LW'(hit_off));
      // carry the free run at the top of the word
      top_one = '0;
      for (int b = 0; b < WB; b++) begin
         if (rd_ff[b]) top_one = BA'(b);
      end
      run_t = (rd_ff == '0) ? 13'(run_ff + 13'(WB)) : 13'(BA'(WB - 1) - top_one);
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         bra_pkg::ST_IDLE: begin
            if (job_valid && !rmw_ff && job.cmd == bra_pkg::CMD_SCAN && !job.bad_count)
               st_in = bra_pkg::ST_SCAN;
            else if (job_valid && !rmw_ff && job.cmd == bra_pkg::CMD_CLEAR)
               st_in = bra_pkg::ST_CLEAR;
         end
         bra_pkg::ST_SCAN: begin
            if (rd_ok_ff && (hit || (LW'(base_ff + LW'(WB)) >= len) ||
                             widx_ff == (WA+1)'(bra_pkg::STORE_WORDS)))
               st_in = bra_pkg::ST_IDLE;
            else if (!rd_ok_ff && (LW'(base_ff) >= len))
               st_in = bra_pkg::ST_IDLE;
         end
         bra_pkg::ST_CLEAR: begin
            if (widx_ff == (WA+1)'(bra_pkg::STORE_WORDS - 1)) st_in = bra_pkg::ST_IDLE;
         end
         default: st_in = bra_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      pop     = 1'b0;
      cur_in  = cur_ff;
      widx_in = widx_ff;
      base_in = base_ff;
      run_in  = run_ff;
      rmw_in  = 1'b0;
      rv_in   = 1'b0;
      rsp_in  = '0;
      mem_we  = 1'b0;
      mem_wa  = cur_ff.word;
      mem_wd  = rd_ff;
      rd_en   = 1'b0;
      rd_addr = job.word;
      case (st_ff)
         bra_pkg::ST_IDLE: begin
            if (rmw_ff) begin
               // finish test or write once the word is read
               rv_in = 1'b1;
               rsp_in.bit_state = (cur_ff.cmd == bra_pkg::CMD_TEST) &&
                                  cur_ff.in_store && rd_ff[cur_ff.bit_pos];
               if (cur_ff.cmd == bra_pkg::CMD_WRITE && cur_ff.in_store) begin
                  mem_we = 1'b1;
                  mem_wd = rd_ff;
                  mem_wd[cur_ff.bit_pos] = cur_ff.bit_value;
               end
            end else if (job_valid) begin
               pop    = 1'b1;
               cur_in = job;
               case (job.cmd)
                  bra_pkg::CMD_SCAN: begin
                     if (job.bad_count) begin
                        rv_in = 1'b1;
                        rsp_in.status = 1'b1;
                     end
                     widx_in = '0;
                     base_in = '0;
                     run_in  = '0;
                  end
                  bra_pkg::CMD_CLEAR: widx_in = '0;
                  default: begin
                     rd_en  = 1'b1;
                     rmw_in = 1'b1;
                  end
               endcase
            end
         end
         bra_pkg::ST_SCAN: begin
            rd_addr = widx_ff[WA-1:0];
            if (rd_ok_ff) begin
               run_in  = run_t;
               base_in = LW'(base_ff + LW'(WB));
               if (hit) begin
                  rv_in = 1'b1;
                  rsp_in.start_index = 12'(hit_pos + 1'b1 - LW'(cur_ff.run_length));
               end else if ((LW'(base_ff + LW'(WB)) >= len) ||
                            widx_ff == (WA+1)'(bra_pkg::STORE_WORDS)) begin
                  rv_in = 1'b1;
                  rsp_in.status = 1'b1;
               end
            end else if (LW'(base_ff) >= len) begin
               rv_in = 1'b1;
               rsp_in.status = 1'b1;
            end
            if (st_in == bra_pkg::ST_SCAN && widx_ff != (WA+1)'(bra_pkg::STORE_WORDS)) begin
               rd_en   = 1'b1;
               widx_in = widx_ff + 1'b1;
            end
         end
         bra_pkg::ST_CLEAR: begin
            mem_we  = 1'b1;
            mem_wa  = widx_ff[WA-1:0];
            mem_wd  = '0;
            widx_in = widx_ff + 1'b1;
            if (st_in == bra_pkg::ST_IDLE) rv_in = 1'b1;
         end
         default: ;
      endcase
   end

   // hold the store, read data registered
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (rd_en)  rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= bra_pkg::ST_CLEAR;
         widx_ff  <= '0;
         rmw_ff   <= 1'b0;
         rv_ff    <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         widx_ff  <= widx_in;
         rmw_ff   <= rmw_in;
         rv_ff    <= rv_in && !(st_ff == bra_pkg::ST_CLEAR && !cur_ok_ff);
         rd_ok_ff <= rd_en && st_ff == bra_pkg::ST_SCAN;
      end
   end

   // clear pass after reset yields no response
   always_ff @(posedge clock) begin
      if (reset) cur_ok_ff <= 1'b0;
      else if (pop) cur_ok_ff <= 1'b1;
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      base_ff <= base_in;
      run_ff  <= run_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   `include "bitmap_run_allocator_top_macros.svh"
   `BRA_ASSERT(a_pop_idle, pop |-> st_ff == bra_pkg::ST_IDLE, "pop outside idle")
   `BRA_ASSERT(a_no_rd_clear, st_ff == bra_pkg::ST_CLEAR |-> !rd_en, "read during clear")
   `BRA_ASSERT(a_fail_zero, rsp_valid && rsp_data.status |-> rsp_data.start_index == '0,
      "failed scan with nonzero start")
endmodule

/* sv/bitmap_run_allocator_top.sv */
// The back end takes one request at a time; a two-entry queue takes requests ahead.
// Scan cost is set by the single read port of the mark store, one 64-bit word per cycle.
// Reset: synchronous; a clearing pass over all 64 words of the store follows, busy may then fill.
// Responses carry a one-cycle strobe; the receiver cannot stall.
module bitmap_run_allocator_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bra_pkg::req_type req_data,
   output logic             rsp_valid,
   output bra_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [1:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [9:0]       map_bytes_ff;
   logic             pop, job_valid;
   bra_pkg::job_type job;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == bra_pkg::REG_MAP_BYTES) ? {22'd0, map_bytes_ff} : 32'd0;

   // write map length register
   always_ff @(posedge clock) begin
      if (reset) map_bytes_ff <= bra_pkg::MAP_BYTES_RESET;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == bra_pkg::REG_MAP_BYTES)
         map_bytes_ff <= csr_pwdata[9:0];
   end

   bra_front u_front (
      .clock, .reset, .start, .busy, .req_data,
      .pop, .job_valid, .job
   );

   bra_back u_back (
      .clock, .reset, .job_valid, .job, .pop,
      .map_bytes(map_bytes_ff), .rsp_valid, .rsp_data
   );
endmodule
